// ===== hw/rtl/fssl_pkg.sv =====
`default_nettype none

package fssl_pkg;

  // Fixed widths of the item fields.
  localparam int DATA_W   = 16;
  localparam int RANK_W   = 4;
  localparam int STAT_W   = 3;
  localparam int LCOUNT_W = 5;
  localparam int QCOUNT_W = 2;

  // Request codes.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_QUEUED    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_SPILLED   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DUP_QUEUE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DUP_LIST  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_READ      = 3'd5;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QSCAN,
    ST_LWALK,
    ST_DECIDE,
    ST_INS_NODE,
    ST_INS_PREV,
    ST_QPUSH,
    ST_RWALK,
    ST_DONE
  } state_t;

  // One result item.
  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [DATA_W-1:0]   spilled_code;
    logic [DATA_W-1:0]   spilled_tag;
    logic [RANK_W-1:0]   insert_rank;
    logic                read_valid;
    logic [DATA_W-1:0]   read_code;
    logic [DATA_W-1:0]   read_tag;
    logic [LCOUNT_W-1:0] list_count;
    logic [QCOUNT_W-1:0] queue_count;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fifo_spill_to_sorted_list.sv =====
`default_nettype none

// Small FIFO of unique codes that spills its oldest entry into a code-sorted
// linked list when full. Items are handled one at a time. For an add, the
// FIFO is scanned one entry a cycle for duplicates (skipped when it is
// empty). Then the whole list is walked one node a cycle to check
// duplicates and find the insertion point. After that come a decide step,
// up to two node writes, the FIFO write, the result step and the idle step
// that takes the next item. A read chases pointers through the node memory,
// one node per cycle, up to read_rank. The result sits in an output
// register, so the next item is taken while the previous result waits. List
// nodes are never freed, so no clearing pass is needed after reset.
module fifo_spill_to_sorted_list #(
  parameter int QUEUE_DEPTH = 3,
  parameter int LIST_DEPTH  = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_req_type,
  input  wire logic [fssl_pkg::DATA_W-1:0]       in_app_code,
  input  wire logic [fssl_pkg::DATA_W-1:0]       in_app_tag,
  input  wire logic [fssl_pkg::RANK_W-1:0]       in_read_rank,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [fssl_pkg::STAT_W-1:0]       out_status,
  output logic      [fssl_pkg::DATA_W-1:0]       out_spilled_code,
  output logic      [fssl_pkg::DATA_W-1:0]       out_spilled_tag,
  output logic      [fssl_pkg::RANK_W-1:0]       out_insert_rank,
  output logic                                   out_read_valid,
  output logic      [fssl_pkg::DATA_W-1:0]       out_read_code,
  output logic      [fssl_pkg::DATA_W-1:0]       out_read_tag,
  output logic      [fssl_pkg::LCOUNT_W-1:0]     out_list_count,
  output logic      [fssl_pkg::QCOUNT_W-1:0]     out_queue_count
);

  localparam int KW  = (KEY_WIDTH < fssl_pkg::DATA_W) ? KEY_WIDTH : fssl_pkg::DATA_W;
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int IW  = $clog2(LIST_DEPTH);
  localparam int PW  = IW + 1;
  localparam int QWW = fssl_pkg::DATA_W + KW;
  localparam int NW  = PW + fssl_pkg::DATA_W + KW;

  logic              q_we;
  logic [QIW-1:0]    q_waddr;
  logic [QWW-1:0]    q_wdata;
  logic [QIW-1:0]    q_raddr;
  logic [QWW-1:0]    q_rdata;
  logic              n_we;
  logic [IW-1:0]     n_waddr;
  logic [NW-1:0]     n_wdata;
  logic [IW-1:0]     n_raddr;
  logic [NW-1:0]     n_rdata;
  logic              res_valid;
  logic              res_ready;
  fssl_pkg::result_t res;
  fssl_pkg::result_t out_r;
  logic              out_valid_r;

  // FIFO entries: tag and code.
  fssl_ram #(
    .WIDTH (QWW),
    .DEPTH (QUEUE_DEPTH),
    .AW    (QIW)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // List nodes: next link, tag and code.
  fssl_ram #(
    .WIDTH (NW),
    .DEPTH (LIST_DEPTH),
    .AW    (IW)
  ) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  fssl_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LIST_DEPTH  (LIST_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_app_code  (in_app_code),
    .in_app_tag   (in_app_tag),
    .in_read_rank (in_read_rank),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .q_we         (q_we),
    .q_waddr      (q_waddr),
    .q_wdata      (q_wdata),
    .q_raddr      (q_raddr),
    .q_rdata      (q_rdata),
    .n_we         (n_we),
    .n_waddr      (n_waddr),
    .n_wdata      (n_wdata),
    .n_raddr      (n_raddr),
    .n_rdata      (n_rdata)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_spilled_code = out_r.spilled_code;
  assign out_spilled_tag  = out_r.spilled_tag;
  assign out_insert_rank  = out_r.insert_rank;
  assign out_read_valid   = out_r.read_valid;
  assign out_read_code    = out_r.read_code;
  assign out_read_tag     = out_r.read_tag;
  assign out_list_count   = out_r.list_count;
  assign out_queue_count  = out_r.queue_count;

endmodule

`default_nettype wire

// ===== hw/rtl/fssl_ram.sv =====
`default_nettype none

module fssl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fssl_ctrl.sv =====
`default_nettype none

module fssl_ctrl #(
  parameter int QUEUE_DEPTH = 3,
  parameter int LIST_DEPTH  = 16,
  parameter int KEY_WIDTH   = 16,
  localparam int KW  = (KEY_WIDTH < fssl_pkg::DATA_W) ? KEY_WIDTH : fssl_pkg::DATA_W,
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int QCW = $clog2(QUEUE_DEPTH + 1),
  localparam int IW  = $clog2(LIST_DEPTH),
  localparam int PW  = IW + 1,
  localparam int LCW = $clog2(LIST_DEPTH + 1),
  localparam int QWW = fssl_pkg::DATA_W + KW,
  localparam int NW  = PW + fssl_pkg::DATA_W + KW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request side.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_req_type,
  input  wire logic [fssl_pkg::DATA_W-1:0]   in_app_code,
  input  wire logic [fssl_pkg::DATA_W-1:0]   in_app_tag,
  input  wire logic [fssl_pkg::RANK_W-1:0]   in_read_rank,
  // Result side.
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output fssl_pkg::result_t                  res,
  // Queue memory.
  output logic                               q_we,
  output logic      [QIW-1:0]                q_waddr,
  output logic      [QWW-1:0]                q_wdata,
  output logic      [QIW-1:0]                q_raddr,
  input  wire logic [QWW-1:0]                q_rdata,
  // Node memory.
  output logic                               n_we,
  output logic      [IW-1:0]                 n_waddr,
  output logic      [NW-1:0]                 n_wdata,
  output logic      [IW-1:0]                 n_raddr,
  input  wire logic [NW-1:0]                 n_rdata
);

  localparam logic [PW-1:0]  NULL_PTR = {1'b1, {IW{1'b0}}};
  localparam logic [QCW-1:0] Q_FULL   = QCW'(QUEUE_DEPTH);
  localparam logic [LCW-1:0] L_FULL   = LCW'(LIST_DEPTH);

  // Circular index add for the queue, both operands below the depth.
  function automatic logic [QIW-1:0] qwrap(input logic [QIW-1:0] a, input logic [QIW-1:0] b);
    logic [QIW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (QIW+1)'(QUEUE_DEPTH)) begin
      s = s - (QIW+1)'(QUEUE_DEPTH);
    end
    return s[QIW-1:0];
  endfunction

  fssl_pkg::state_t state_r, state_nxt;

  logic [KW-1:0]                 key_r, key_nxt;
  logic [fssl_pkg::DATA_W-1:0]   tag_r, tag_nxt;
  logic [fssl_pkg::RANK_W-1:0]   rank_r, rank_nxt;
  logic [QIW-1:0]                q_head_r, q_head_nxt;
  logic [QCW-1:0]                q_fill_r, q_fill_nxt;
  logic [PW-1:0]                 l_head_r, l_head_nxt;
  logic [LCW-1:0]                l_fill_r, l_fill_nxt;
  logic [QCW-1:0]                qi_r, qi_nxt;
  logic                          qpend_r, qpend_nxt;
  logic                          qfirst_r, qfirst_nxt;
  logic [IW-1:0]                 cur_r, cur_nxt;
  logic [fssl_pkg::RANK_W-1:0]   steps_r, steps_nxt;
  logic                          dup_q_r, dup_q_nxt;
  logic                          dup_l_r, dup_l_nxt;
  logic [KW-1:0]                 sp_code_r, sp_code_nxt;
  logic [fssl_pkg::DATA_W-1:0]   sp_tag_r, sp_tag_nxt;
  logic                          ins_stop_r, ins_stop_nxt;
  logic [PW-1:0]                 ins_prev_r, ins_prev_nxt;
  logic [PW-1:0]                 ins_next_r, ins_next_nxt;
  logic [LCW-1:0]                ins_rank_r, ins_rank_nxt;
  logic [KW-1:0]                 prev_code_r, prev_code_nxt;
  logic [fssl_pkg::DATA_W-1:0]   prev_tag_r, prev_tag_nxt;
  fssl_pkg::result_t             res_r, res_nxt;

  // Fields of the node word that arrives from memory.
  logic [KW-1:0]               nd_code;
  logic [fssl_pkg::DATA_W-1:0] nd_tag;
  logic [PW-1:0]               nd_next;
  logic                        nd_last;
  logic                        head_null;
  logic                        qdone;
  logic                        q_full;
  logic                        accept;

  assign nd_code   = n_rdata[KW-1:0];
  assign nd_tag    = n_rdata[KW +: fssl_pkg::DATA_W];
  assign nd_next   = n_rdata[KW + fssl_pkg::DATA_W +: PW];
  assign nd_last   = nd_next[PW-1];
  assign head_null = l_head_r[PW-1];
  assign qdone     = !qpend_r && (qi_r == q_fill_r);
  assign q_full    = (q_fill_r == Q_FULL);
  assign accept    = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fssl_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req_type == fssl_pkg::REQ_READ) begin
            state_nxt = head_null ? fssl_pkg::ST_DONE : fssl_pkg::ST_RWALK;
          end else if (q_fill_r != '0) begin
            state_nxt = fssl_pkg::ST_QSCAN;
          end else begin
            state_nxt = head_null ? fssl_pkg::ST_DECIDE : fssl_pkg::ST_LWALK;
          end
        end
      end
      fssl_pkg::ST_QSCAN: begin
        if (qdone) begin
          if (dup_q_r) begin
            state_nxt = fssl_pkg::ST_DONE;
          end else begin
            state_nxt = head_null ? fssl_pkg::ST_DECIDE : fssl_pkg::ST_LWALK;
          end
        end
      end
      fssl_pkg::ST_LWALK: begin
        if (nd_last) begin
          state_nxt = fssl_pkg::ST_DECIDE;
        end
      end
      fssl_pkg::ST_DECIDE: begin
        if (dup_l_r) begin
          state_nxt = fssl_pkg::ST_DONE;
        end else if (q_full && (l_fill_r != L_FULL)) begin
          state_nxt = fssl_pkg::ST_INS_NODE;
        end else begin
          state_nxt = fssl_pkg::ST_QPUSH;
        end
      end
      fssl_pkg::ST_INS_NODE: begin
        state_nxt = ins_prev_r[PW-1] ? fssl_pkg::ST_QPUSH : fssl_pkg::ST_INS_PREV;
      end
      fssl_pkg::ST_INS_PREV: begin
        state_nxt = fssl_pkg::ST_QPUSH;
      end
      fssl_pkg::ST_QPUSH: begin
        state_nxt = fssl_pkg::ST_DONE;
      end
      fssl_pkg::ST_RWALK: begin
        if ((steps_r == rank_r) || nd_last) begin
          state_nxt = fssl_pkg::ST_DONE;
        end
      end
      fssl_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = fssl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fssl_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    rank_nxt      = rank_r;
    q_head_nxt    = q_head_r;
    q_fill_nxt    = q_fill_r;
    l_head_nxt    = l_head_r;
    l_fill_nxt    = l_fill_r;
    qi_nxt        = qi_r;
    qpend_nxt     = qpend_r;
    qfirst_nxt    = qfirst_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    dup_q_nxt     = dup_q_r;
    dup_l_nxt     = dup_l_r;
    sp_code_nxt   = sp_code_r;
    sp_tag_nxt    = sp_tag_r;
    ins_stop_nxt  = ins_stop_r;
    ins_prev_nxt  = ins_prev_r;
    ins_next_nxt  = ins_next_r;
    ins_rank_nxt  = ins_rank_r;
    prev_code_nxt = prev_code_r;
    prev_tag_nxt  = prev_tag_r;
    res_nxt       = res_r;
    q_we          = 1'b0;
    q_waddr       = '0;
    q_wdata       = {tag_r, key_r};
    q_raddr       = '0;
    n_we          = 1'b0;
    n_waddr       = '0;
    n_wdata       = {ins_next_r, sp_tag_r, sp_code_r};
    n_raddr       = l_head_r[IW-1:0];
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    res           = res_r;

    case (state_r)
      fssl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // Take the item and clear the per-item bookkeeping.
        if (accept) begin
          key_nxt      = in_app_code[KW-1:0];
          tag_nxt      = in_app_tag;
          rank_nxt     = in_read_rank;
          qi_nxt       = '0;
          qpend_nxt    = 1'b0;
          qfirst_nxt   = 1'b0;
          steps_nxt    = '0;
          dup_q_nxt    = 1'b0;
          dup_l_nxt    = 1'b0;
          ins_stop_nxt = 1'b0;
          ins_prev_nxt = NULL_PTR;
          ins_next_nxt = NULL_PTR;
          ins_rank_nxt = '0;
          cur_nxt      = l_head_r[IW-1:0];
          res_nxt      = '0;
          res_nxt.status = (in_req_type == fssl_pkg::REQ_READ) ?
                           fssl_pkg::STAT_READ : fssl_pkg::STAT_QUEUED;
        end
      end
      fssl_pkg::ST_QSCAN: begin
        // Compare the entry read last cycle; the oldest one is the spill candidate.
        if (qpend_r) begin
          if (q_rdata[KW-1:0] == key_r) begin
            dup_q_nxt = 1'b1;
          end
          if (qfirst_r) begin
            sp_code_nxt = q_rdata[KW-1:0];
            sp_tag_nxt  = q_rdata[KW +: fssl_pkg::DATA_W];
          end
        end
        // Issue the next queue read while entries remain.
        if (qi_r != q_fill_r) begin
          q_raddr    = qwrap(q_head_r, QIW'(qi_r));
          qi_nxt     = qi_r + 1'b1;
          qpend_nxt  = 1'b1;
          qfirst_nxt = (qi_r == '0);
        end else begin
          qpend_nxt  = 1'b0;
        end
        if (qdone && dup_q_r) begin
          res_nxt.status = fssl_pkg::STAT_DUP_QUEUE;
        end
        cur_nxt = l_head_r[IW-1:0];
      end
      fssl_pkg::ST_LWALK: begin
        // Duplicate check of the new code against every listed node.
        if (nd_code == key_r) begin
          dup_l_nxt = 1'b1;
        end
        // Insertion point of the spill: after all codes not above it.
        if (!ins_stop_r) begin
          if (nd_code <= sp_code_r) begin
            ins_prev_nxt  = {1'b0, cur_r};
            prev_code_nxt = nd_code;
            prev_tag_nxt  = nd_tag;
            ins_rank_nxt  = ins_rank_r + 1'b1;
          end else begin
            ins_stop_nxt  = 1'b1;
            ins_next_nxt  = {1'b0, cur_r};
          end
        end
        // Follow the link straight from the read data.
        n_raddr = nd_next[IW-1:0];
        cur_nxt = nd_next[IW-1:0];
      end
      fssl_pkg::ST_DECIDE: begin
        if (dup_l_r) begin
          res_nxt.status = fssl_pkg::STAT_DUP_LIST;
        end else if (q_full) begin
          // Oldest entry leaves the queue.
          q_head_nxt = qwrap(q_head_r, QIW'(1));
          q_fill_nxt = QCW'(QUEUE_DEPTH - 1);
          res_nxt.spilled_code = fssl_pkg::DATA_W'(sp_code_r);
          res_nxt.spilled_tag  = sp_tag_r;
          if (l_fill_r != L_FULL) begin
            res_nxt.status      = fssl_pkg::STAT_SPILLED;
            res_nxt.insert_rank = fssl_pkg::RANK_W'(ins_rank_r);
          end else begin
            res_nxt.status      = fssl_pkg::STAT_DROPPED;
          end
        end
      end
      fssl_pkg::ST_INS_NODE: begin
        // New node takes the next unused slot; slots are never freed.
        n_we    = 1'b1;
        n_waddr = IW'(l_fill_r);
        n_wdata = {ins_next_r, sp_tag_r, sp_code_r};
        if (ins_prev_r[PW-1]) begin
          l_head_nxt = {1'b0, IW'(l_fill_r)};
          l_fill_nxt = l_fill_r + 1'b1;
        end
      end
      fssl_pkg::ST_INS_PREV: begin
        // Relink the predecessor to the new node.
        n_we       = 1'b1;
        n_waddr    = ins_prev_r[IW-1:0];
        n_wdata    = {1'b0, IW'(l_fill_r), prev_tag_r, prev_code_r};
        l_fill_nxt = l_fill_r + 1'b1;
      end
      fssl_pkg::ST_QPUSH: begin
        q_we       = 1'b1;
        q_waddr    = qwrap(q_head_r, QIW'(q_fill_r));
        q_wdata    = {tag_r, key_r};
        q_fill_nxt = q_fill_r + 1'b1;
      end
      fssl_pkg::ST_RWALK: begin
        // Step through the list until the requested rank or its end.
        if (steps_r == rank_r) begin
          res_nxt.read_valid = 1'b1;
          res_nxt.read_code  = fssl_pkg::DATA_W'(nd_code);
          res_nxt.read_tag   = nd_tag;
        end else begin
          n_raddr   = nd_next[IW-1:0];
          cur_nxt   = nd_next[IW-1:0];
          steps_nxt = steps_r + 1'b1;
        end
      end
      fssl_pkg::ST_DONE: begin
        res_valid       = 1'b1;
        res.list_count  = fssl_pkg::LCOUNT_W'(l_fill_r);
        res.queue_count = fssl_pkg::QCOUNT_W'(q_fill_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fssl_pkg::ST_IDLE;
      q_head_r <= '0;
      q_fill_r <= '0;
      l_head_r <= NULL_PTR;
      l_fill_r <= '0;
    end else begin
      state_r  <= state_nxt;
      q_head_r <= q_head_nxt;
      q_fill_r <= q_fill_nxt;
      l_head_r <= l_head_nxt;
      l_fill_r <= l_fill_nxt;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    tag_r       <= tag_nxt;
    rank_r      <= rank_nxt;
    qi_r        <= qi_nxt;
    qpend_r     <= qpend_nxt;
    qfirst_r    <= qfirst_nxt;
    cur_r       <= cur_nxt;
    steps_r     <= steps_nxt;
    dup_q_r     <= dup_q_nxt;
    dup_l_r     <= dup_l_nxt;
    sp_code_r   <= sp_code_nxt;
    sp_tag_r    <= sp_tag_nxt;
    ins_stop_r  <= ins_stop_nxt;
    ins_prev_r  <= ins_prev_nxt;
    ins_next_r  <= ins_next_nxt;
    ins_rank_r  <= ins_rank_nxt;
    prev_code_r <= prev_code_nxt;
    prev_tag_r  <= prev_tag_nxt;
    res_r       <= res_nxt;
  end

endmodule

`default_nettype wire
